>>> rtl/lcdnw_pkg.sv
// ---------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, codes and command tables for the character LCD nibble
// write sequencer.
// ---------------------------------------------------------------------------
package lcdnw_pkg;

    // Request kinds carried in the func field of an input word.
    localparam logic [1:0] FUNC_INIT = 2'd0;
    localparam logic [1:0] FUNC_CMD  = 2'd1;
    localparam logic [1:0] FUNC_POS  = 2'd2;
    localparam logic [1:0] FUNC_CHAR = 2'd3;

    // Status codes reported on the final word of a request.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_POWER_UP_WAIT    = 2'd0;
    localparam logic [1:0] REG_SECOND_INIT_WAIT = 2'd1;
    localparam logic [1:0] REG_SHORT_INIT_WAIT  = 2'd2;
    localparam logic [1:0] REG_BYTE_WAIT        = 2'd3;

    localparam logic [15:0] RST_POWER_UP_WAIT    = 16'd15000;
    localparam logic [15:0] RST_SECOND_INIT_WAIT = 16'd5000;
    localparam logic [15:0] RST_SHORT_INIT_WAIT  = 16'd250;
    localparam logic [15:0] RST_BYTE_WAIT        = 16'd1000;

    // Controller commands.
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] LINE2_OFFSET     = 8'h40;

    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;

    // Init request: three wake-up nibbles and one four-bit-mode nibble, then five command bytes.
    localparam int          INIT_STEPS     = 14;
    localparam int          STEP_W         = 4;
    localparam logic [3:0]  INIT_LAST_STEP = 4'(INIT_STEPS - 1);
    localparam logic [3:0]  INIT_BYTE_STEP = 4'd4;

    localparam int DEFAULT_COLUMNS     = 16;
    localparam int DEFAULT_LINES       = 2;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        JOB_BYTE   = 3'b001,
        JOB_INIT   = 3'b010,
        JOB_STATUS = 3'b100
    } job_kind_t;

    // One unit of work handed from the front to the back.
    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] data;
        logic [1:0] status;
    } job_t;

    typedef struct packed {
        logic [15:0] power_up_wait;
        logic [15:0] second_init_wait;
        logic [15:0] short_init_wait;
        logic [15:0] byte_wait;
    } wait_cfg_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CMD_FUNCTION_SET;
            3'd1:    b = CMD_DISPLAY_ON;
            3'd2:    b = CMD_CLEAR;
            3'd3:    b = CMD_ENTRY_MODE;
            3'd4:    b = CMD_SET_DDRAM;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] init_nibble(input logic [3:0] step);
        logic [3:0] idx;
        logic [7:0] b;
        logic [3:0] nib;
        idx = step - INIT_BYTE_STEP;
        b   = init_byte(idx[3:1]);
        if (step < 4'd3)
        begin
            nib = WAKE_NIBBLE;
        end
        else if (step == 4'd3)
        begin
            nib = FOUR_BIT_NIBBLE;
        end
        else
        begin
            // Even steps carry the high nibble of a command byte.
            nib = step[0] ? b[3:0] : b[7:4];
        end
        return nib;
    endfunction

endpackage

>>> rtl/lcdnw_req_if.sv
// ---------------------------------------------------------------------------
// lcdnw_req_if
// Request channel: one word per LCD request.
// ---------------------------------------------------------------------------
interface lcdnw_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [7:0]        value;
    logic signed [7:0] column;
    logic signed [7:0] row;
    logic              last_char;

    modport source (output valid, func, value, column, row, last_char, input ready);
    modport sink   (input valid, func, value, column, row, last_char, output ready);
endinterface

>>> rtl/lcdnw_res_if.sv
// ---------------------------------------------------------------------------
// lcdnw_res_if
// Result channel: one word per enable strobe or status report.
// ---------------------------------------------------------------------------
interface lcdnw_res_if;
    logic        valid;
    logic        ready;
    logic        strobe_res;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, strobe_res, reg_select, nibble, wait_before, status, last,
                    input ready);
    modport sink   (input valid, strobe_res, reg_select, nibble, wait_before, status, last,
                    output ready);
endinterface

>>> rtl/lcdnw_front.sv
// ---------------------------------------------------------------------------
// lcdnw_front
// Accepts request words, checks positions, tracks the print room and turns
// each request into at most one job for the back end.
// ---------------------------------------------------------------------------
module lcdnw_front #(
    parameter int COLUMNS = lcdnw_pkg::DEFAULT_COLUMNS,
    parameter int LINES   = lcdnw_pkg::DEFAULT_LINES
) (
    input  logic             clk,
    input  logic             rst_n,
    lcdnw_req_if.sink        req,
    output logic             job_push,
    output lcdnw_pkg::job_t  job,
    input  logic             job_full
);

    localparam int         ROOM_W   = $clog2(COLUMNS + 2);
    localparam logic [7:0] COL_MAX  = 8'(COLUMNS);
    localparam logic [7:0] ROW_MAX  = 8'(LINES);
    localparam logic [ROOM_W-1:0] ROOM_FULL = ROOM_W'(COLUMNS + 1);

    logic              armed_reg;
    logic              armed_next;
    logic [ROOM_W-1:0] room_reg;
    logic [ROOM_W-1:0] room_next;

    logic              accept;
    logic              want_push;
    logic              pos_ok;
    logic              has_room;
    logic [ROOM_W-1:0] room_dec;
    logic [ROOM_W-1:0] room_init;
    logic [7:0]        ddram_base;
    logic [7:0]        pos_byte;

    assign req.ready = !job_full;
    assign accept    = req.valid && req.ready;
    assign job_push  = accept && want_push;

    // Negative values fail on the sign bit; the rest compare as unsigned.
    assign pos_ok = !req.column[7] && ($unsigned(req.column) <= COL_MAX) &&
                    !req.row[7]    && ($unsigned(req.row) <= ROW_MAX);

    assign has_room   = (room_reg != '0);
    assign room_dec   = room_reg - ROOM_W'(has_room);
    assign room_init  = ROOM_FULL - ROOM_W'($unsigned(req.column));
    assign ddram_base = (req.row == 8'sd2)
                        ? (lcdnw_pkg::CMD_SET_DDRAM + lcdnw_pkg::LINE2_OFFSET)
                        : lcdnw_pkg::CMD_SET_DDRAM;
    assign pos_byte   = ddram_base + $unsigned(req.column);

    always_comb
    begin
        want_push  = 1'b0;
        job.kind   = lcdnw_pkg::JOB_BYTE;
        job.rs     = 1'b0;
        job.data   = req.value;
        job.status = lcdnw_pkg::ST_OK;
        armed_next = armed_reg;
        room_next  = room_reg;
        case (req.func)
            lcdnw_pkg::FUNC_INIT:
            begin
                want_push = 1'b1;
                job.kind  = lcdnw_pkg::JOB_INIT;
            end
            lcdnw_pkg::FUNC_CMD:
            begin
                want_push = 1'b1;
            end
            lcdnw_pkg::FUNC_POS:
            begin
                if (pos_ok)
                begin
                    armed_next = 1'b1;
                    room_next  = room_init;
                    job.data   = pos_byte;
                    // Line zero only arms the print.
                    want_push  = (req.row != 8'sd0);
                end
                else
                begin
                    armed_next = 1'b0;
                    room_next  = '0;
                    want_push  = 1'b1;
                    job.kind   = lcdnw_pkg::JOB_STATUS;
                    job.status = lcdnw_pkg::ST_INVALID;
                end
            end
            lcdnw_pkg::FUNC_CHAR:
            begin
                job.rs = 1'b1;
                if (!armed_reg)
                begin
                    want_push = 1'b1;
                end
                else
                begin
                    if (has_room)
                    begin
                        want_push = 1'b1;
                        room_next = room_dec;
                    end
                    if (req.last_char)
                    begin
                        job.status = (room_dec == '0) ? lcdnw_pkg::ST_TRUNC
                                                      : lcdnw_pkg::ST_OK;
                        if (!has_room)
                        begin
                            want_push = 1'b1;
                            job.kind  = lcdnw_pkg::JOB_STATUS;
                        end
                        armed_next = 1'b0;
                        room_next  = '0;
                    end
                end
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            room_reg  <= '0;
        end
        else if (accept)
        begin
            armed_reg <= armed_next;
            room_reg  <= room_next;
        end
    end

endmodule

>>> rtl/lcdnw_queue.sv
// ---------------------------------------------------------------------------
// lcdnw_queue
// Short job FIFO between the request front end and the strobe back end.
// ---------------------------------------------------------------------------
module lcdnw_queue #(
    parameter int DEPTH = lcdnw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdnw_pkg::job_t  push_job,
    output logic             full,
    input  logic             pop,
    output lcdnw_pkg::job_t  head_job,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lcdnw_pkg::job_t  entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/lcdnw_back.sv
// ---------------------------------------------------------------------------
// lcdnw_back
// Expands each job into nibble strobe words, or a status word, one per
// cycle while the output is not stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module lcdnw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  lcdnw_pkg::job_t       job,
    output logic                  job_pop,
    input  lcdnw_pkg::wait_cfg_t  cfg,
    lcdnw_res_if.source           res
);

    logic [lcdnw_pkg::STEP_W-1:0] step_reg;
    logic [lcdnw_pkg::STEP_W-1:0] step_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        strobe_reg;
    logic        rs_reg;
    logic [3:0]  nibble_reg;
    logic [15:0] wait_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    logic        load;
    logic        c_strobe;
    logic        c_rs;
    logic [3:0]  c_nibble;
    logic [15:0] c_wait;
    logic [1:0]  c_status;
    logic        c_final;
    logic [16:0] first_wait_sum;
    logic [15:0] first_wait;

    assign load    = job_valid && (!out_valid_reg || res.ready);
    assign job_pop = load && c_final;

    // The first command byte of init waits both delays, saturated to 16 bits.
    assign first_wait_sum = {1'b0, cfg.short_init_wait} + {1'b0, cfg.byte_wait};
    assign first_wait     = first_wait_sum[16] ? 16'hFFFF : first_wait_sum[15:0];

    always_comb
    begin
        c_strobe = 1'b1;
        c_rs     = job.rs;
        c_nibble = step_reg[0] ? job.data[3:0] : job.data[7:4];
        c_wait   = step_reg[0] ? 16'd0 : cfg.byte_wait;
        c_status = lcdnw_pkg::ST_OK;
        c_final  = step_reg[0];
        case (job.kind)
            lcdnw_pkg::JOB_BYTE:
            begin
                c_status = step_reg[0] ? job.status : lcdnw_pkg::ST_OK;
            end
            lcdnw_pkg::JOB_INIT:
            begin
                c_rs     = 1'b0;
                c_nibble = lcdnw_pkg::init_nibble(step_reg);
                c_final  = (step_reg == lcdnw_pkg::INIT_LAST_STEP);
                case (step_reg)
                    4'd0:    c_wait = cfg.power_up_wait;
                    4'd1:    c_wait = cfg.second_init_wait;
                    4'd2:    c_wait = cfg.short_init_wait;
                    4'd3:    c_wait = cfg.short_init_wait;
                    4'd4:    c_wait = first_wait;
                    default: c_wait = step_reg[0] ? 16'd0 : cfg.byte_wait;
                endcase
            end
            lcdnw_pkg::JOB_STATUS:
            begin
                c_strobe = 1'b0;
                c_rs     = 1'b0;
                c_nibble = 4'd0;
                c_wait   = 16'd0;
                c_status = job.status;
                c_final  = 1'b1;
            end
            default:
            begin
                c_strobe = 1'b0;
                c_final  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = c_final ? '0 : step_reg + 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            strobe_reg <= c_strobe;
            rs_reg     <= c_rs;
            nibble_reg <= c_nibble;
            wait_reg   <= c_wait;
            status_reg <= c_status;
            last_reg   <= c_final;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.strobe_res  = strobe_reg;
    assign res.reg_select  = rs_reg;
    assign res.nibble      = nibble_reg;
    assign res.wait_before = wait_reg;
    assign res.status      = status_reg;
    assign res.last        = last_reg;

endmodule

>>> rtl/char_lcd_nibble_write_sequencer_core.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core
// Turns character LCD requests into 4-bit enable strobes with wait times.
//
//   channel  direction  word
//   req      in         func, value, column, row, last_char
//   res      out        strobe_res, reg_select, nibble, wait_before, status, last
//   cfg      in         cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// A byte request gives two output words in the strobe back end, init gives
// fourteen, a status report one. The back end's one-word-per-cycle expansion
// sets the rate while the result is not stalled; requests enter at one per cycle
// while the job queue has room. Reset clears the print state, the queue and
// the output stage and loads the default waits. A stalled result stalls the
// back end only; the front end keeps taking requests until the queue fills.
// ---------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer_core #(
    parameter int COLUMNS     = lcdnw_pkg::DEFAULT_COLUMNS,
    parameter int LINES       = lcdnw_pkg::DEFAULT_LINES,
    parameter int QUEUE_DEPTH = lcdnw_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    lcdnw_req_if.sink   req,
    lcdnw_res_if.source res,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    lcdnw_pkg::wait_cfg_t cfg_reg;

    logic            job_push;
    lcdnw_pkg::job_t push_job;
    logic            job_full;
    logic            job_pop;
    lcdnw_pkg::job_t head_job;
    logic            job_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_up_wait    <= lcdnw_pkg::RST_POWER_UP_WAIT;
            cfg_reg.second_init_wait <= lcdnw_pkg::RST_SECOND_INIT_WAIT;
            cfg_reg.short_init_wait  <= lcdnw_pkg::RST_SHORT_INIT_WAIT;
            cfg_reg.byte_wait        <= lcdnw_pkg::RST_BYTE_WAIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lcdnw_pkg::REG_POWER_UP_WAIT:    cfg_reg.power_up_wait    <= cfg_wdata;
                lcdnw_pkg::REG_SECOND_INIT_WAIT: cfg_reg.second_init_wait <= cfg_wdata;
                lcdnw_pkg::REG_SHORT_INIT_WAIT:  cfg_reg.short_init_wait  <= cfg_wdata;
                lcdnw_pkg::REG_BYTE_WAIT:        cfg_reg.byte_wait        <= cfg_wdata;
                default:                         cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    lcdnw_front #(
        .COLUMNS (COLUMNS),
        .LINES   (LINES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .job_push (job_push),
        .job      (push_job),
        .job_full (job_full)
    );

    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (job_empty)
    );

    lcdnw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (head_job),
        .job_pop   (job_pop),
        .cfg       (cfg_reg),
        .res       (res)
    );

endmodule
